@@ sv/ple_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

	// item codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [1:0] KIND_LINEAR   = 2'd0;
	localparam logic [1:0] KIND_CONSTANT = 2'd1;
	localparam logic [1:0] KIND_TO_ZERO  = 2'd2;

	localparam logic [2:0] ST_INTERP    = 3'd0;
	localparam logic [2:0] ST_CLAMP_LO  = 3'd1;
	localparam logic [2:0] ST_CLAMP_HI  = 3'd2;
	localparam logic [2:0] ST_LOADED    = 3'd3;
	localparam logic [2:0] ST_UNSORTED  = 3'd4;

	localparam int TIME_W = 48;
	localparam int Y_W    = 32;

	// front to back queue entry
	typedef struct packed {
		logic                     opcode;
		logic [3:0]               point_index;
		logic signed [TIME_W-1:0] time_value;
		logic [1:0]               segment_kind;
		logic signed [Y_W-1:0]    param_value;
	} item_t;

	// back end sequencer
	typedef enum logic [3:0] {
		B_IDLE,
		B_LOAD_RD,
		B_LOAD_WR,
		B_RD_FIRST,
		B_RD_LAST,
		B_CLAMP,
		B_SEARCH,
		B_SEG_RD,
		B_SEG_CHK,
		B_MUL,
		B_DIV,
		B_FIN,
		B_OUT
	} back_state_t;

endpackage
`default_nettype wire

@@ sv/ple_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ple_front #(
	parameter int DEPTH = 2
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  ple_pkg::item_t     in_item,
	output logic               q_valid,
	input  wire                q_ready,
	output ple_pkg::item_t     q_item
);
	import ple_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t           fifo_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= in_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

@@ sv/ple_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle, 81-bit dividend.
// quotient saturates at 2^41 which exceeds every later clamp.
module ple_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [80:0] dividend,
	input  wire  [47:0] divisor,
	output logic        done,
	output logic [41:0] quotient
);
	logic [80:0] num_q;
	logic [48:0] rem_q;
	logic [41:0] quo_q;
	logic        big_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [48:0] trial, rem_sh;

	assign rem_sh   = {rem_q[47:0], num_q[80]};
	assign trial    = rem_sh - {1'b0, divisor};
	assign quotient = (big_q || quo_q[41]) ? {1'b1, 41'd0} : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd81;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// shift-subtract step
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[79:0], 1'b0};
			if (quo_q[41]) big_q <= 1'b1;
			if (!trial[48]) begin
				rem_q <= trial;
				quo_q <= {quo_q[40:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[40:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/ple_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ple_back #(
	parameter int MAX_POINTS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire  [4:0]               point_count,
	input  wire                      q_valid,
	output logic                     q_ready,
	input  ple_pkg::item_t           q_item,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic signed [31:0]       result_value,
	output logic [2:0]               status
);
	import ple_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int NW = IW + 1;

	// table memories: one write port, one registered read port
	logic signed [TIME_W-1:0] time_mem [MAX_POINTS];
	logic signed [Y_W-1:0]    y_mem    [MAX_POINTS];
	logic [1:0]               kind_mem [MAX_POINTS];
	logic [IW-1:0]            rd_addr, wr_addr;
	logic                     wr_en;
	logic signed [TIME_W-1:0] rd_time_q, wr_time;
	logic signed [Y_W-1:0]    rd_y_q, wr_y;
	logic [1:0]               rd_kind_q;

	back_state_t state_q, state_d;
	item_t       q_item_s;
	logic [IW-1:0] idx_q;
	logic [NW-1:0] n_eff;
	logic signed [TIME_W-1:0] t_prev_q;
	logic signed [Y_W-1:0]    y_prev_q;
	logic signed [Y_W-1:0]    res_q;
	logic [2:0]               st_q;
	logic                     neg_q;
	logic [TIME_W-1:0]        den_q;
	logic [32:0]              ady_q;
	logic [80:0]              mcand_q;
	logic [80:0]              prod_q;
	logic [5:0]               mul_cnt_q;
	logic                     div_start, div_done;
	logic [41:0]              quo;
	logic                     take;
	logic                     idx_ok;
	logic                     x_lo, x_hi;
	logic                     state_hold_q, flat_q;
	logic signed [Y_W:0]      dy;
	logic signed [TIME_W:0]   dnum, dden;
	logic signed [42:0]       sum;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_addr] <= wr_time;
			y_mem[wr_addr]    <= wr_y;
			kind_mem[wr_addr] <= q_item_s.segment_kind;
		end
		rd_time_q <= time_mem[rd_addr];
		rd_y_q    <= y_mem[rd_addr];
		rd_kind_q <= kind_mem[rd_addr];
	end

	assign take = (state_q == B_IDLE) && q_valid;
	assign q_ready = (state_q == B_IDLE);
	assign idx_ok = (int'(q_item_s.point_index) < MAX_POINTS);

	// clamp tests: t_prev holds first point, rd holds last
	assign x_lo = (q_item_s.time_value <= t_prev_q);
	assign x_hi = (q_item_s.time_value >= rd_time_q);

	// effective point count
	always_comb begin
		if (point_count < 5'd2) n_eff = NW'(2);
		else if (int'(point_count) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
		else n_eff = NW'(point_count);
	end

	ple_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(prod_q), .divisor(den_q),
		.done(div_done), .quotient(quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:     if (q_valid) state_d = (q_item.opcode == OP_LOAD) ? B_LOAD_RD : B_RD_FIRST;
			B_LOAD_RD:  state_d = B_LOAD_WR;
			B_LOAD_WR:  state_d = B_OUT;
			B_RD_FIRST: state_d = B_RD_LAST;
			B_RD_LAST:  state_d = B_CLAMP;
			B_CLAMP:    state_d = (x_lo || x_hi) ? B_OUT : B_SEARCH;
			B_SEARCH:   state_d = B_SEG_RD;
			B_SEG_RD:   state_d = B_SEG_CHK;
			B_SEG_CHK:  state_d = state_hold_q ? B_MUL : B_SEARCH;
			B_MUL:      if (mul_cnt_q == 6'd0) state_d = B_DIV;
			B_DIV:      if (div_done) state_d = B_FIN;
			B_FIN:      state_d = B_OUT;
			B_OUT:      if (out_ready) state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	// read address and write strobe
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = IW'(q_item_s.point_index);
		wr_time = q_item_s.time_value;
		wr_y    = q_item_s.param_value;
		div_start = (state_q == B_MUL) && (mul_cnt_q == 6'd0);
		case (state_q)
			B_LOAD_RD:  rd_addr = IW'(q_item_s.point_index - 4'd1);
			B_LOAD_WR: begin
				wr_en = idx_ok;
				if (q_item_s.point_index != 4'd0 && q_item_s.segment_kind == KIND_CONSTANT)
					wr_y = rd_y_q;
				else if (q_item_s.point_index != 4'd0 && q_item_s.segment_kind == KIND_TO_ZERO)
					wr_y = '0;
			end
			B_RD_FIRST: rd_addr = '0;
			B_RD_LAST:  rd_addr = IW'(n_eff - 1'b1);
			B_SEARCH, B_SEG_RD: rd_addr = idx_q;
			B_CLAMP:    rd_addr = '0;
			default:    rd_addr = idx_q;
		endcase
	end

	assign dy   = {rd_y_q[Y_W-1], rd_y_q} - {y_prev_q[Y_W-1], y_prev_q};
	assign dnum = {q_item_s.time_value[TIME_W-1], q_item_s.time_value}
	              - {t_prev_q[TIME_W-1], t_prev_q};
	assign dden = {rd_time_q[TIME_W-1], rd_time_q} - {t_prev_q[TIME_W-1], t_prev_q};
	assign sum  = {{11{y_prev_q[Y_W-1]}}, y_prev_q}
	              + (neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: if (take) begin
				q_item_s <= q_item;
				idx_q    <= IW'(1);
			end
			B_LOAD_WR: begin
				res_q <= idx_ok ? wr_y : '0;
				st_q  <= (idx_ok && q_item_s.point_index != 4'd0
				          && q_item_s.time_value <= rd_time_q) ? ST_UNSORTED : ST_LOADED;
			end
			B_RD_FIRST: ;
			B_RD_LAST: begin
				// rd holds first point
				t_prev_q <= rd_time_q;
				y_prev_q <= rd_y_q;
			end
			B_CLAMP: begin
				if (x_lo) begin
					res_q <= y_prev_q; st_q <= ST_CLAMP_LO;
				end else if (x_hi) begin
					res_q <= rd_y_q; st_q <= ST_CLAMP_HI;
				end else st_q <= ST_INTERP;
			end
			B_SEARCH: ;
			B_SEG_RD: begin
				// rd holds point idx; stop at first time >= x or at the last point
				if (rd_time_q >= q_item_s.time_value || idx_q == IW'(n_eff - 1'b1)) begin
					state_hold_q <= 1'b1;
				end else begin
					t_prev_q <= rd_time_q;
					y_prev_q <= rd_y_q;
					idx_q    <= idx_q + 1'b1;
					state_hold_q <= 1'b0;
				end
			end
			B_SEG_CHK: begin
				neg_q     <= dy[Y_W] ^ dnum[TIME_W];
				ady_q     <= dy[Y_W] ? 33'(-dy) : 33'(dy);
				mcand_q   <= {32'd0, (dnum[TIME_W] ? 49'(-dnum) : 49'(dnum))};
				prod_q    <= '0;
				mul_cnt_q <= 6'd33;
				den_q     <= dden[TIME_W-1:0];
				flat_q    <= (rd_kind_q == KIND_CONSTANT) || dden[TIME_W] || (dden == '0);
			end
			// shift-add multiply, one multiplier bit per cycle
			B_MUL: if (mul_cnt_q != 6'd0) begin
				if (ady_q[0]) prod_q <= prod_q + mcand_q;
				mcand_q   <= {mcand_q[79:0], 1'b0};
				ady_q     <= {1'b0, ady_q[32:1]};
				mul_cnt_q <= mul_cnt_q - 6'd1;
			end
			B_FIN: begin
				if (flat_q) res_q <= y_prev_q;
				else if (sum > 43'sd2147483647) res_q <= 32'sh7fffffff;
				else if (sum < -43'sd2147483648) res_q <= 32'sh80000000;
				else res_q <= sum[31:0];
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	// outputs
	always_comb begin
		out_valid    = (state_q == B_OUT);
		result_value = res_q;
		status       = st_q;
	end
endmodule
`default_nettype wire

@@ sv/piecewise_linear_evaluator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake                word
// s_axis    in   s_axis_tvalid/tready     tdata: index, time, kind, param; tuser opcode
// m_axis    out  m_axis_tvalid/tready     tdata: result_value[31:0], status[34:32]
// cfg       in   cfg_valid/cfg_ready      point_count[4:0]
// A load reads the previous point, then writes. A clamped evaluate reads
// the first and last points; an interpolated one then searches point by
// point and runs a 33-step shift-add multiply and the 81-step serial divider.
// The sequencer returns to idle after each result; a two-entry queue
// decouples input from it. Output holds while m_axis_tready is low.
// arst_n clears control state; table contents are undefined until loaded.
module piecewise_linear_evaluator #(
	parameter int MAX_POINTS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [87:0] s_axis_tdata,  // point_index, time_value, segment_kind, param_value
	input  wire         s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,  // result_value, status
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [4:0]  cfg_data       // point_count
);
	import ple_pkg::*;

	logic [4:0] point_count_q;
	item_t in_item, q_item;
	logic q_valid, q_ready;
	logic signed [31:0] result_value;
	logic [2:0] status;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) point_count_q <= 5'd2;
		else if (cfg_valid) point_count_q <= cfg_data;
	end

	assign in_item.opcode       = s_axis_tuser;
	assign in_item.point_index  = s_axis_tdata[3:0];
	assign in_item.time_value   = s_axis_tdata[51:4];
	assign in_item.segment_kind = s_axis_tdata[53:52];
	assign in_item.param_value  = s_axis_tdata[85:54];

	ple_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	ple_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk), .arst_n(arst_n), .point_count(point_count_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.result_value(result_value), .status(status)
	);

	assign m_axis_tdata = {5'd0, status, result_value};
endmodule
`default_nettype wire

@@ sv/ple_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ple_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [39:0] m_axis_tdata
);
	// status never beyond unsorted code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[34:32] <= 3'd4))
		else $error("bad status");
	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output dropped");
	// a result never appears the cycle after being taken
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
		else $error("duplicate result");
	// no output right after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !m_axis_tvalid)
		else $error("output after reset");
endmodule

bind piecewise_linear_evaluator ple_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

@@ sim/piecewise_linear_evaluator_tb.sv @@
`timescale 1ns / 1ps
module piecewise_linear_evaluator_tb;
	import ple_pkg::*;

	localparam int NPTS = 16;

	// expected output word
	typedef struct {
		logic signed [31:0] y;
		logic [2:0]         status;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = 5'd0;

	piecewise_linear_evaluator #(.MAX_POINTS(NPTS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	longint          tbl_time[NPTS];
	int              tbl_y[NPTS];
	logic [1:0]      tbl_kind[NPTS];
	logic [4:0]      pt_count = 5'd2;

	item_t    pending_items[$];
	outcome_t expected_words[$];
	item_t    cur_item;
	logic     in_fire = 1'b0;
	bit       failed = 1'b0;

	// shadow of loaded times, used only to aim queries
	longint   aim_time[NPTS];

	// y0 + dy*num/den, quotient truncated toward zero, sum saturated
	function automatic logic signed [31:0] interp_y(longint y0, longint y1, longint num,
			longint den);
		longint    dy;
		bit        neg;
		logic [127:0] ady, anum, q;
		longint    r;
		dy = y1 - y0;
		neg = (dy < 0) != (num < 0);
		ady = (dy < 0) ? 128'(-dy) : 128'(dy);
		anum = (num < 0) ? 128'(-num) : 128'(num);
		q = (ady * anum) / 128'(den);
		if (q > (128'd1 << 40))
			q = 128'd1 << 40;
		r = neg ? y0 - longint'(q[63:0]) : y0 + longint'(q[63:0]);
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// apply one word to the table model and return the expected output
	function automatic outcome_t table_step(item_t it);
		outcome_t o;
		longint   x, den;
		int       n, i;
		x = longint'(it.time_value);
		o.y = '0;
		if (it.opcode == OP_LOAD) begin
			o.status = ST_LOADED;
			i = it.point_index;
			if (i == 0 || it.segment_kind == KIND_LINEAR || it.segment_kind == 2'd3)
				o.y = it.param_value;
			else if (it.segment_kind == KIND_CONSTANT)
				o.y = tbl_y[i-1];
			if (i > 0 && x <= tbl_time[i-1])
				o.status = ST_UNSORTED;
			tbl_time[i] = x;
			tbl_y[i] = o.y;
			tbl_kind[i] = it.segment_kind;
		end else begin
			n = pt_count;
			if (n < 2)
				n = 2;
			if (n > NPTS)
				n = NPTS;
			if (x <= tbl_time[0]) begin
				o.y = tbl_y[0];
				o.status = ST_CLAMP_LO;
			end else if (x >= tbl_time[n-1]) begin
				o.y = tbl_y[n-1];
				o.status = ST_CLAMP_HI;
			end else begin
				o.status = ST_INTERP;
				i = 1;
				while (i < n - 1 && tbl_time[i] < x)
					i++;
				den = tbl_time[i] - tbl_time[i-1];
				if (tbl_kind[i] == KIND_CONSTANT || den <= 0)
					o.y = tbl_y[i-1];
				else
					o.y = interp_y(tbl_y[i-1], tbl_y[i], x - tbl_time[i-1], den);
			end
		end
		return o;
	endfunction

	// sample input handshake and predict
	always @(posedge clk) begin
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			expected_words.push_back(table_step(cur_item));
	end

	// sender: bursts with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && !in_fire)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				s_axis_tdata <= {2'b00, cur_item.param_value, cur_item.segment_kind,
					cur_item.time_value, cur_item.point_index};
				s_axis_tuser <= cur_item.opcode;
				s_axis_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stall pattern, picked from four modes
	int rx_cnt = 0;
	int rx_mode = 0;
	always @(negedge clk) begin
		rx_cnt <= rx_cnt + 1;
		if (rx_cnt % 64 == 63)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= (rx_cnt % 5) != 0;
		endcase
	end

	// output checker
	always @(posedge clk) begin
		outcome_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected output word %h", m_axis_tdata);
				failed = 1'b1;
			end else begin
				want = expected_words.pop_front();
				if (m_axis_tdata[31:0] !== want.y) begin
					$error("result_value expected %h actual %h", want.y, m_axis_tdata[31:0]);
					failed = 1'b1;
				end
				if (m_axis_tdata[34:32] !== want.status) begin
					$error("status expected %0d actual %0d", want.status,
						m_axis_tdata[34:32]);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic add_load(int idx, longint t, logic [1:0] kind, logic [31:0] p);
		item_t it;
		it.opcode = OP_LOAD;
		it.point_index = idx[3:0];
		it.time_value = t[47:0];
		it.segment_kind = kind;
		it.param_value = p;
		pending_items.push_back(it);
		aim_time[idx] = t;
	endtask

	task automatic add_eval(longint t);
		item_t it;
		it.opcode = OP_EVAL;
		it.point_index = 4'($urandom);
		it.time_value = t[47:0];
		it.segment_kind = 2'($urandom);
		it.param_value = $urandom;
		pending_items.push_back(it);
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !s_axis_tvalid && expected_words.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_count(logic [4:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pt_count = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic longint rand48();
		longint r;
		r = {$urandom, $urandom};
		return longint'(signed'(r[47:0]));
	endfunction

	// stimulus
	initial begin
		longint base, t, lo, span;
		int     k, ph, n;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every kind, unsorted and zero-span segments
		write_count(5'd2);
		add_load(0, -(64'sd1 <<< 47), KIND_LINEAR, 32'h7fffffff);
		add_load(1, -1000, KIND_CONSTANT, 32'h0badf00d);
		add_load(2, 0, KIND_TO_ZERO, 32'h55555555);
		add_load(3, 1000, 2'd3, 32'h80000000);
		add_load(4, 1000, KIND_LINEAR, 32'h00050000);
		add_load(5, 500, KIND_LINEAR, 32'h12345678);
		for (k = 6; k < 15; k++)
			add_load(k, 2000 + k * 1000, 2'(k % 3), $urandom);
		add_load(15, (64'sd1 <<< 47) - 1, KIND_LINEAR, 32'hffffffff);
		add_eval(-2000);
		drain();
		write_count(5'd16);
		add_eval(-(64'sd1 <<< 47));
		add_eval((64'sd1 <<< 47) - 1);
		add_eval(-(64'sd1 <<< 47) + 1);
		add_eval(-500);
		add_eval(999);
		add_eval(1000);
		add_eval(750);
		add_eval(20000);
		drain();

		// random phases: mostly sorted table, then mostly queries
		for (ph = 0; ph < 17; ph++) begin
			case (ph)
				0: write_count(5'd2);
				1: write_count(5'd16);
				2: write_count(5'd0);
				3: write_count(5'd31);
				default: write_count(5'($urandom_range(0, 31)));
			endcase
			n = pt_count < 2 ? 2 : (pt_count > NPTS ? NPTS : pt_count);
			base = -(longint'($urandom) << $urandom_range(0, 14));
			t = base;
			for (k = 0; k < NPTS; k++) begin
				if ($urandom_range(0, 11) == 0)
					add_load(k, t - $urandom_range(0, 50), 2'($urandom), $urandom);
				else
					add_load(k, t, 2'($urandom), $urandom);
				t = t + 1 + ({$urandom, $urandom} & ((64'd1 << $urandom_range(0, 40)) - 1));
			end
			for (k = 0; k < 34; k++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: add_load($urandom_range(0, NPTS - 1), rand48(), 2'($urandom),
						$urandom);
					3, 4: add_eval(aim_time[$urandom_range(0, NPTS - 1)]);
					5, 6: add_eval(rand48());
					default: begin
						lo = aim_time[0];
						span = aim_time[n-1] - lo;
						if (span < 0)
							span = -span;
						add_eval(lo - 1 + longint'({$urandom, $urandom} % (span + 3)));
					end
				endcase
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (!failed && expected_words.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
